/* design/cleb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cleb_pkg
// Shared types, constants and index helpers of the console line edit buffer.
// ----------------------------------------------------------------------------
package cleb_pkg;

  // Ring geometry. Indices count modulo twice the ring depth.
  localparam int unsigned BUF_DEPTH = 128;
  localparam int unsigned IDX_MOD   = 2 * BUF_DEPTH;
  localparam int unsigned IDX_W     = $clog2(IDX_MOD);
  localparam int unsigned SLOT_W    = $clog2(BUF_DEPTH);
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned EXT_W     = (IDX_W > CHAR_W) ? IDX_W : CHAR_W + 1;

  typedef logic [IDX_W-1:0]  cleb_idx_t;
  typedef logic [SLOT_W-1:0] cleb_slot_t;
  typedef logic [CHAR_W-1:0] cleb_char_t;

  // Control characters
  localparam cleb_char_t CH_NUL    = 8'h00;
  localparam cleb_char_t CH_CTRL_D = 8'h04;
  localparam cleb_char_t CH_CTRL_H = 8'h08;
  localparam cleb_char_t CH_CTRL_P = 8'h10;
  localparam cleb_char_t CH_CTRL_U = 8'h15;
  localparam cleb_char_t CH_DEL    = 8'h7F;
  localparam cleb_char_t CH_CR     = 8'h0D;
  localparam cleb_char_t CH_LF     = 8'h0A;
  localparam cleb_char_t ERASE_MAX = 8'hFF;

  typedef enum logic {
    OP_RX   = 1'b0,
    OP_READ = 1'b1
  } cleb_op_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_BYTE = 2'd1,
    RD_EOF  = 2'd2
  } cleb_rd_status_t;

  typedef struct packed {
    logic            echo_valid;
    cleb_char_t      echo_char;
    cleb_char_t      erase_count;
    logic            line_ready;
    logic            dump_request;
    cleb_rd_status_t read_status;
    cleb_char_t      read_byte;
  } cleb_result_t;

  typedef struct packed {
    cleb_idx_t read_idx;
    cleb_idx_t commit_idx;
    cleb_idx_t edit_idx;
  } cleb_ptrs_t;

  typedef struct packed {
    logic       en;
    cleb_slot_t addr;
    cleb_char_t data;
  } cleb_wr_t;

  function automatic cleb_idx_t idx_inc(cleb_idx_t a);
    return (a == cleb_idx_t'(IDX_MOD - 1)) ? '0 : a + cleb_idx_t'(1);
  endfunction

  function automatic cleb_idx_t idx_dec(cleb_idx_t a);
    return (a == '0) ? cleb_idx_t'(IDX_MOD - 1) : a - cleb_idx_t'(1);
  endfunction

  function automatic cleb_idx_t idx_dist(cleb_idx_t hi, cleb_idx_t lo);
    logic [IDX_W:0] wrap;
    wrap = {1'b0, hi} + (IDX_W + 1)'(IDX_MOD) - {1'b0, lo};
    return (hi >= lo) ? hi - lo : wrap[IDX_W-1:0];
  endfunction

  function automatic cleb_slot_t idx_slot(cleb_idx_t a);
    cleb_idx_t folded;
    folded = (a >= cleb_idx_t'(BUF_DEPTH)) ? a - cleb_idx_t'(BUF_DEPTH) : a;
    return folded[SLOT_W-1:0];
  endfunction

  function automatic cleb_char_t erase_sat(cleb_idx_t d);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(d);
    return (ext > EXT_W'(ERASE_MAX)) ? ERASE_MAX : ext[CHAR_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/cleb_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cleb_in_if / cleb_out_if
// Valid/ready channels for requests into and results out of the buffer.
// ----------------------------------------------------------------------------
interface cleb_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_char;
  logic       first_of_read;

  modport source (output valid, opcode, rx_char, first_of_read, input ready);
  modport sink   (input valid, opcode, rx_char, first_of_read, output ready);
endinterface

interface cleb_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [7:0] erase_count;
  logic       line_ready;
  logic       dump_request;
  logic [1:0] read_status;
  logic [7:0] read_byte;

  modport source (output valid, echo_valid, echo_char, erase_count, line_ready,
                  dump_request, read_status, read_byte, input ready);
  modport sink   (input valid, echo_valid, echo_char, erase_count, line_ready,
                  dump_request, read_status, read_byte, output ready);
endinterface
`default_nettype wire

/* design/console_line_edit_buffer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// console_line_edit_buffer_top
// Cooked-mode console input buffer: ring of received bytes with edit support.
// ----------------------------------------------------------------------------
// Each request is either a received character (stored, echoed, erased or
// committed as a line) or a read of one committed byte; every request gives
// exactly one result, shown in the next cycle in an output register. It
// keeps taking requests as long as that register is empty or being drained
// in the same cycle, so the sustained rate is one request per cycle, set by
// the output register, while the receiver takes results. The byte at the
// read index is fetched ahead from the line store RAM (registered read), so
// a read request does not wait on the RAM. The line store has no reset and
// no clearing pass; only committed slots, always written first, are read.
// ----------------------------------------------------------------------------
module console_line_edit_buffer_top
  import cleb_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  cleb_in_if.sink    in_ch,
  cleb_out_if.source out_ch
);

  cleb_ptrs_t   ptrs_r;
  cleb_ptrs_t   ptrs_nxt;
  cleb_ptrs_t   core_ptrs;
  cleb_wr_t     core_wr;
  cleb_result_t core_res;
  cleb_result_t res_r;
  logic         out_valid_r;
  logic         in_fire;
  logic         wr_en;
  cleb_slot_t   rd_addr;
  cleb_char_t   ram_rd_data;
  logic         fwd_r;
  cleb_char_t   fwd_data_r;
  cleb_char_t   head_byte;

  // Accept while the result register is empty or being taken this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Byte at the read index: take the forwarded write when the prefetch
  // collided with a store write to the same slot.
  assign head_byte = fwd_r ? fwd_data_r : ram_rd_data;

  cleb_core u_core (
    .opcode        (in_ch.opcode),
    .rx_char       (in_ch.rx_char),
    .first_of_read (in_ch.first_of_read),
    .ptrs          (ptrs_r),
    .head_byte     (head_byte),
    .ptrs_nxt      (core_ptrs),
    .wr            (core_wr),
    .res           (core_res)
  );

  // Advance the indices only on an accepted request.
  assign ptrs_nxt = in_fire ? core_ptrs : ptrs_r;
  assign wr_en    = in_fire && core_wr.en;

  // Prefetch the slot the read index will point at next cycle.
  assign rd_addr = idx_slot(ptrs_nxt.read_idx);

  cleb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUF_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (core_wr.addr),
    .wr_data (core_wr.data),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // Index and handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptrs_r      <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      ptrs_r <= ptrs_nxt;
      fwd_r  <= wr_en && (core_wr.addr == rd_addr);
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold the result until taken; hold the forwarded byte.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= core_res;
    end
    fwd_data_r <= core_wr.data;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.echo_valid   = res_r.echo_valid;
  assign out_ch.echo_char    = res_r.echo_char;
  assign out_ch.erase_count  = res_r.erase_count;
  assign out_ch.line_ready   = res_r.line_ready;
  assign out_ch.dump_request = res_r.dump_request;
  assign out_ch.read_status  = res_r.read_status;
  assign out_ch.read_byte    = res_r.read_byte;

endmodule
`default_nettype wire

/* design/cleb_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cleb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cleb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

/* design/cleb_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cleb_core
// Line discipline decode: next indices, store write and result of a request.
// ----------------------------------------------------------------------------
module cleb_core
  import cleb_pkg::*;
(
  input  wire logic         opcode,
  input  wire cleb_char_t   rx_char,
  input  wire logic         first_of_read,
  input  wire cleb_ptrs_t   ptrs,
  input  wire cleb_char_t   head_byte,
  output      cleb_ptrs_t   ptrs_nxt,
  output      cleb_wr_t     wr,
  output      cleb_result_t res
);

  cleb_idx_t  edit_inc;
  cleb_idx_t  fill;
  cleb_char_t ch;

  assign edit_inc = idx_inc(ptrs.edit_idx);
  assign fill     = idx_dist(ptrs.edit_idx, ptrs.read_idx);
  assign ch       = (rx_char == CH_CR) ? CH_LF : rx_char;

  always_comb begin
    ptrs_nxt = ptrs;
    wr.en    = 1'b0;
    wr.addr  = idx_slot(ptrs.edit_idx);
    wr.data  = ch;
    res      = '0;

    if (opcode == OP_RX) begin
      if (rx_char == CH_CTRL_P) begin
        res.dump_request = 1'b1;
      end else if (rx_char == CH_CTRL_U) begin
        res.erase_count   = erase_sat(idx_dist(ptrs.edit_idx, ptrs.commit_idx));
        ptrs_nxt.edit_idx = ptrs.commit_idx;
      end else if (rx_char == CH_CTRL_H || rx_char == CH_DEL) begin
        if (ptrs.edit_idx != ptrs.commit_idx) begin
          ptrs_nxt.edit_idx = idx_dec(ptrs.edit_idx);
          res.erase_count   = 8'd1;
        end
      end else if (rx_char != CH_NUL && fill < cleb_idx_t'(BUF_DEPTH)) begin
        wr.en             = 1'b1;
        res.echo_valid    = 1'b1;
        res.echo_char     = ch;
        ptrs_nxt.edit_idx = edit_inc;
        // commit on newline, end of file or a ring that is now full
        if (ch == CH_LF || ch == CH_CTRL_D || fill == cleb_idx_t'(BUF_DEPTH - 1)) begin
          ptrs_nxt.commit_idx = edit_inc;
          res.line_ready      = 1'b1;
        end
      end
    end else if (ptrs.read_idx != ptrs.commit_idx) begin
      if (head_byte == CH_CTRL_D) begin
        res.read_status = RD_EOF;
        if (first_of_read) begin
          ptrs_nxt.read_idx = idx_inc(ptrs.read_idx);
        end
      end else begin
        res.read_status   = RD_BYTE;
        res.read_byte     = head_byte;
        ptrs_nxt.read_idx = idx_inc(ptrs.read_idx);
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/console_line_edit_buffer_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_line_edit_buffer_top_tb
// Self-checking bench for the cooked-mode console input buffer. A directed
// table walks the control characters, the empty-line and end-of-file cases,
// then typed lines, noise, a ring-filling burst and reads run with random
// gaps on both channels. Every result is compared with a line-discipline
// predictor that keeps its own ring and indices.
// ----------------------------------------------------------------------------
module console_line_edit_buffer_top_tb;
  import cleb_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 40;

  localparam cleb_result_t NO_EFFECT = '0;

  // One request as the input channel carries it
  typedef struct packed {
    cleb_op_t   op;
    cleb_char_t ch;
    logic       first;
  } edit_req_t;

  // Directed row: the expected result is typed in only where typed is set
  typedef struct {
    edit_req_t    req;
    bit           typed;
    cleb_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  cleb_in_if  in_ch ();
  cleb_out_if out_ch ();

  console_line_edit_buffer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: ring contents and the read, commit and edit indices
  cleb_char_t line_mem [BUF_DEPTH];
  cleb_idx_t  rd_idx;
  cleb_idx_t  cm_idx;
  cleb_idx_t  ed_idx;

  cleb_result_t awaited_results[$];
  dir_row_t     directed_rows[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned live_requests;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          hold_flip;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: apply one request to the shadow ring and return its result.
  // Indices wrap at twice the depth, so plain 8-bit arithmetic gives the
  // distances; the slot is the low part of an index.
  // --------------------------------------------------------------------------
  function automatic cleb_result_t predict_line_edit(edit_req_t r);
    cleb_result_t res;
    cleb_char_t   c;
    cleb_char_t   b;
    res = NO_EFFECT;
    if (r.op == OP_RX) begin
      c = r.ch;
      if (c == CH_CTRL_P) begin
        res.dump_request = 1'b1;
      end else if (c == CH_CTRL_U) begin
        // kill the uncommitted line in one go
        res.erase_count = cleb_char_t'(cleb_idx_t'(ed_idx - cm_idx));
        ed_idx = cm_idx;
      end else if (c == CH_CTRL_H || c == CH_DEL) begin
        if (ed_idx != cm_idx) begin
          ed_idx = ed_idx - 1'b1;
          res.erase_count = 8'd1;
        end
      end else if (c != CH_NUL &&
                   cleb_idx_t'(ed_idx - rd_idx) < cleb_idx_t'(BUF_DEPTH)) begin
        if (c == CH_CR) c = CH_LF;
        res.echo_valid = 1'b1;
        res.echo_char  = c;
        line_mem[ed_idx[SLOT_W-1:0]] = c;
        ed_idx = ed_idx + 1'b1;
        // newline, end of file or a full ring commits the line
        if (c == CH_LF || c == CH_CTRL_D ||
            cleb_idx_t'(ed_idx - rd_idx) == cleb_idx_t'(BUF_DEPTH)) begin
          cm_idx = ed_idx;
          res.line_ready = 1'b1;
        end
      end
    end else if (rd_idx != cm_idx) begin
      b = line_mem[rd_idx[SLOT_W-1:0]];
      if (b == CH_CTRL_D) begin
        // end of file stays in the ring unless it opens the read
        res.read_status = RD_EOF;
        if (r.first) rd_idx = rd_idx + 1'b1;
      end else begin
        res.read_status = RD_BYTE;
        res.read_byte   = b;
        rd_idx = rd_idx + 1'b1;
      end
    end
    return res;
  endfunction

  function automatic cleb_result_t outcome(logic ev, cleb_char_t ec, cleb_char_t er,
                                           logic lr, logic dp, cleb_rd_status_t st,
                                           cleb_char_t rb);
    return '{ev, ec, er, lr, dp, st, rb};
  endfunction

  function automatic void add_row(cleb_op_t op, cleb_char_t ch, logic first, bit typed,
                                  cleb_result_t res);
    dir_row_t row;
    row.req   = '{op, ch, first};
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: idle at random, then hold the request until it is taken. The
  // expectation is queued in the step of acceptance, ahead of the earliest
  // result.
  // --------------------------------------------------------------------------
  task automatic issue_request(input edit_req_t r, input bit typed,
                               input cleb_result_t typed_res);
    cleb_result_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= r.op;
    in_ch.rx_char       <= r.ch;
    in_ch.first_of_read <= r.first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = predict_line_edit(r);
    if (typed) want = typed_res;
    awaited_results.push_back(want);
    // a received NUL is simply ignored, so leave it out of the tally
    if (!(r.op == OP_RX && r.ch == CH_NUL)) live_requests++;
  endtask

  task automatic send_rx(input cleb_char_t ch);
    issue_request('{OP_RX, ch, 1'($urandom_range(1))}, 1'b0, NO_EFFECT);
  endtask

  task automatic send_read(input logic first);
    issue_request('{OP_READ, cleb_char_t'($urandom_range(255)), first}, 1'b0, NO_EFFECT);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (awaited_results.size() == 0);
  endtask

  // Type one line with random content and edits, then read some of it back
  task automatic type_and_read_line();
    int unsigned len;
    int unsigned n;
    cleb_char_t  c;
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(19))
        0:       c = CH_CTRL_H;
        1:       c = CH_DEL;
        2:       c = CH_CTRL_U;
        3:       c = CH_CTRL_P;
        4:       c = CH_NUL;
        default: c = cleb_char_t'($urandom_range(32, 255));
      endcase
      send_rx(c);
    end
    // now and then leave the line open so edits reach across later reads
    if ($urandom_range(7) != 0) begin
      case ($urandom_range(3))
        0:       send_rx(CH_CR);
        1:       send_rx(CH_CTRL_D);
        default: send_rx(CH_LF);
      endcase
    end
    n = $urandom_range(0, len + 4);
    for (int i = 0; i < n; i++)
      send_read(i == 0 || $urandom_range(7) == 0);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++)
      issue_request('{cleb_op_t'($urandom_range(1)), cleb_char_t'($urandom_range(255)),
                      1'($urandom_range(1))}, 1'b0, NO_EFFECT);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check each accepted result against the oldest expectation and
  // stall at random. A flip of hold_flip starts a long hold-off, counted here.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned  hold_left;
    bit           hold_seen;
    cleb_result_t want;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ch.valid && out_ch.ready) begin
          if (awaited_results.size() == 0) begin
            $error("result with no request outstanding");
            mismatch_count++;
          end else begin
            want = awaited_results.pop_front();
            compare_field("echo_valid",   8'(want.echo_valid),   8'(out_ch.echo_valid));
            compare_field("echo_char",    want.echo_char,        out_ch.echo_char);
            compare_field("erase_count",  want.erase_count,      out_ch.erase_count);
            compare_field("line_ready",   8'(want.line_ready),   8'(out_ch.line_ready));
            compare_field("dump_request", 8'(want.dump_request), 8'(out_ch.dump_request));
            compare_field("read_status",  8'(want.read_status),  8'(out_ch.read_status));
            compare_field("read_byte",    want.read_byte,        out_ch.read_byte);
          end
        end
        if (hold_flip != hold_seen) begin
          hold_seen = hold_flip;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned goal;
    idle_pct       = 0;
    stall_pct      = 0;
    live_requests  = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    hold_flip      = 1'b0;
    rd_idx = '0;
    cm_idx = '0;
    ed_idx = '0;
    foreach (line_mem[i]) line_mem[i] = CH_NUL;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_RX;
    in_ch.rx_char       <= CH_NUL;
    in_ch.first_of_read <= 1'b0;

    // Directed table. Empty ring first: reads and erases do nothing
    add_row(OP_READ, CH_NUL,    1'b1, 1'b1, NO_EFFECT);
    add_row(OP_RX,   CH_NUL,    1'b1, 1'b1, NO_EFFECT);
    add_row(OP_RX,   CH_CTRL_H, 1'b0, 1'b1, NO_EFFECT);
    add_row(OP_RX,   CH_DEL,    1'b0, 1'b1, NO_EFFECT);
    add_row(OP_RX,   CH_CTRL_U, 1'b0, 1'b1, NO_EFFECT);
    add_row(OP_RX,   CH_CTRL_P, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'd0, 1'b0, 1'b1, RD_NONE, 8'h00));
    // extremes of the character code, one erased, CR turned into LF
    add_row(OP_RX,   8'h01,     1'b0, 1'b1,
            outcome(1'b1, 8'h01, 8'd0, 1'b0, 1'b0, RD_NONE, 8'h00));
    add_row(OP_RX,   8'hFF,     1'b1, 1'b1,
            outcome(1'b1, 8'hFF, 8'd0, 1'b0, 1'b0, RD_NONE, 8'h00));
    add_row(OP_RX,   8'h80,     1'b0, 1'b0, NO_EFFECT);
    add_row(OP_RX,   CH_DEL,    1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'd1, 1'b0, 1'b0, RD_NONE, 8'h00));
    add_row(OP_RX,   CH_CR,     1'b0, 1'b1,
            outcome(1'b1, CH_LF, 8'd0, 1'b1, 1'b0, RD_NONE, 8'h00));
    add_row(OP_READ, 8'hFF,     1'b1, 1'b1,
            outcome(1'b0, 8'h00, 8'd0, 1'b0, 1'b0, RD_BYTE, 8'h01));
    add_row(OP_READ, CH_NUL,    1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'd0, 1'b0, 1'b0, RD_BYTE, 8'hFF));
    add_row(OP_READ, CH_NUL,    1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'd0, 1'b0, 1'b0, RD_BYTE, CH_LF));
    add_row(OP_READ, CH_NUL,    1'b1, 1'b1, NO_EFFECT);
    // kill a partial line, then end of file held until a fresh read takes it
    add_row(OP_RX,   8'h78,     1'b0, 1'b0, NO_EFFECT);
    add_row(OP_RX,   8'h7E,     1'b0, 1'b0, NO_EFFECT);
    add_row(OP_RX,   CH_CTRL_U, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'd2, 1'b0, 1'b0, RD_NONE, 8'h00));
    add_row(OP_RX,   CH_CTRL_D, 1'b0, 1'b1,
            outcome(1'b1, CH_CTRL_D, 8'd0, 1'b1, 1'b0, RD_NONE, 8'h00));
    add_row(OP_READ, CH_NUL,    1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'd0, 1'b0, 1'b0, RD_EOF, 8'h00));
    add_row(OP_READ, CH_NUL,    1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'd0, 1'b0, 1'b0, RD_EOF, 8'h00));
    add_row(OP_READ, CH_NUL,    1'b1, 1'b1,
            outcome(1'b0, 8'h00, 8'd0, 1'b0, 1'b0, RD_EOF, 8'h00));
    add_row(OP_READ, CH_NUL,    1'b1, 1'b1, NO_EFFECT);
    add_row(OP_RX,   CH_CTRL_H, 1'b0, 1'b1, NO_EFFECT);
    add_row(OP_RX,   8'h71,     1'b0, 1'b0, NO_EFFECT);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    // Random part in four idling phases: none, sender idle, receiver
    // stalling, both. Pause for the results to drain between phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      goal = live_requests + PHASE_ITEMS;
      if (phase == 0) begin
        // hold the receiver off while requests keep coming, so the
        // output register fills and the input stalls behind it
        hold_flip = ~hold_flip;
        repeat (3) type_and_read_line();
      end
      while (live_requests < goal) begin
        if ($urandom_range(9) < 8)
          type_and_read_line();
        else
          send_noise();
      end
      settle();
    end

    // Fill the ring without reading: the last slot commits the line and the
    // bytes after it are dropped. Then drain it with fresh reads.
    for (int i = 0; i < BUF_DEPTH + 8; i++)
      send_rx(cleb_char_t'($urandom_range(32, 126)));
    send_rx(CH_CTRL_H);
    for (int i = 0; i < BUF_DEPTH + 4; i++)
      send_read(1'b1);
    type_and_read_line();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
